// ===== rtl/core/alh_pkg.sv =====
// ----------------------------------------------------------------------------
// alh_pkg
// Types, constants and helpers shared by the drive history limiter.
// ----------------------------------------------------------------------------
package alh_pkg;

  localparam int unsigned HIST_DEPTH_DEF = 16;

  // widths of the limiter datapath
  localparam int unsigned LEN_W  = 34;  // squared length of the velocity change
  localparam int unsigned R_W    = 68;  // remainder of the offset recurrence
  localparam int unsigned M_W    = 16;  // scaled offset magnitude
  localparam int unsigned STEP_W = 18;  // allowed step

  localparam logic [47:0]       STEP_SAT_LIM = 48'd131073000;
  localparam logic [STEP_W-1:0] STEP_CLAMP   = 18'd131072;
  localparam logic [STEP_W-1:0] STEP_FLOOR   = 18'd1;
  // ceil(2^37 / 1000), exact for products below 2^27
  localparam logic [27:0]       RECIP_1000   = 28'd137438954;

  localparam logic CFG_IDX_TRANS = 1'b0;
  localparam logic CFG_IDX_ROT   = 1'b1;

  typedef enum logic {
    ACT_ADD   = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_STEP_MUL,
    ST_STEP,
    ST_PP_LO,
    ST_PP_HI,
    ST_START,
    ST_REC,
    ST_SCAN,
    ST_WRITE
  } alh_state_e;

  typedef struct packed {
    action_e            action;
    logic [31:0]        time_ms;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] rot_rate;
    logic               kick_in;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] out_vel_x;
    logic signed [15:0] out_vel_y;
    logic signed [15:0] out_rot_rate;
    logic               out_kick;
    logic               trans_limited;
    logic               rot_limited;
  } out_word_t;

  typedef struct packed {
    logic [31:0]        time_ms;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
    logic signed [15:0] rot;
    logic               kick;
  } hist_entry_t;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/alh_cell.sv =====
// ----------------------------------------------------------------------------
// alh_cell
// One history entry; loads from its neighbor when the chain moves.
// ----------------------------------------------------------------------------
module alh_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  alh_pkg::hist_entry_t d_i,
  output alh_pkg::hist_entry_t q_o
);
  import alh_pkg::*;

  hist_entry_t entry_q;

  // history starts zeroed
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (en_i) begin
      entry_q <= d_i;
    end
  end

  assign q_o = entry_q;

endmodule

// ===== rtl/core/alh_recur.sv =====
// ----------------------------------------------------------------------------
// alh_recur
// Bit-serial search for the largest m with m^2 * len2 <= r0, one bit a cycle.
// ----------------------------------------------------------------------------
module alh_recur (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [alh_pkg::R_W-1:0]   r0_i,
  input  logic [alh_pkg::LEN_W-1:0] len2_i,
  output logic                      busy_o,
  output logic [alh_pkg::M_W-1:0]   m_o
);
  import alh_pkg::*;

  localparam int unsigned BIT_W = $clog2(M_W);

  logic [R_W-1:0]   rem_q;
  logic [R_W-1:0]   prod_q;   // len2 * m so far
  logic [LEN_W-1:0] len2_q;
  logic [M_W-1:0]   m_q;
  logic [BIT_W-1:0] bit_q;
  logic             busy_q;
  logic [R_W-1:0]   len2_ext;
  logic [R_W-1:0]   trial;
  logic             fits;

  // (m + 2^b)^2 * len2 - m^2 * len2 = (P << (b+1)) + (len2 << 2b)
  assign len2_ext = R_W'(len2_q);
  assign trial    = (prod_q << ({1'b0, bit_q} + (BIT_W+1)'(1)))
                  + (len2_ext << {bit_q, 1'b0});
  assign fits     = rem_q >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      bit_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      bit_q  <= BIT_W'(M_W - 1);
    end else if (busy_q) begin
      if (bit_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        bit_q <= bit_q - BIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= r0_i;
      prod_q <= '0;
      m_q    <= '0;
      len2_q <= len2_i;
    end else if (busy_q && fits) begin
      rem_q      <= rem_q - trial;
      prod_q     <= prod_q + (len2_ext << bit_q);
      m_q[bit_q] <= 1'b1;
    end
  end

  assign busy_o = busy_q;
  assign m_o    = m_q;

endmodule

// ===== rtl/core/accel_limited_drive_history_top.sv =====
// ----------------------------------------------------------------------------
// accel_limited_drive_history_top
// Acceleration-limited drive command history with time lookup.
// ----------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  in       in   in_valid_i/in_stall_o  in_data_i   (in_word_t)
//  out      out  out_valid_o/out_stall_i out_data_o (out_word_t)
//  cfg      in   cfg_we_i               cfg_idx_i, cfg_data_i
//
//  add: accept, difference, step and partial products, then the offset search.
//  query: the history chain rotates once past the scan.
//  one word in flight; a new word is taken while the result waits on out.
//  reset clears the history chain, the write pointer is implicit in the chain.
// ----------------------------------------------------------------------------
module accel_limited_drive_history_top #(
  parameter int unsigned HISTORY_DEPTH = alh_pkg::HIST_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  alh_pkg::in_word_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output alh_pkg::out_word_t out_data_o,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  import alh_pkg::*;

  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH);

  alh_state_e state_q, state_d;

  logic [15:0] max_trans_q, max_rot_q;

  hist_entry_t cell_q [HISTORY_DEPTH];
  hist_entry_t head_in, new_entry, tail;
  logic        chain_en;

  in_word_t    cmd_q;
  hist_entry_t old_q;

  logic signed [16:0] dx, dy, dr;
  logic signed [16:0] dx_q, dy_q, dr_q;
  logic [16:0]        abs_dx, abs_dy, abs_dr;
  logic [32:0]        dt;
  logic               dtpos_q;
  logic [47:0]        prod_t_q, prod_r_q;
  logic [31:0]        dx2_q, dy2_q;
  logic [15:0]        adr_q;

  logic [LEN_W-1:0]   len2_q;
  logic               satt_q, satr_q;
  logic [54:0]        qmt_q, qmr_q;

  logic [STEP_W-1:0]  st_d, sr_d, st_q, sr_q;
  logic [35:0]        m2_q;

  logic               tlim_q, rlim_q;
  logic [48:0]        plx_q, ply_q;
  logic [R_W-1:0]     r0x_q, r0y_q;

  logic               rec_start, busy_x, busy_y;
  logic [M_W-1:0]     mx, my;

  logic [CNT_W-1:0]   scan_cnt_q;
  logic               run_q;
  hist_entry_t        found_q;

  logic               out_valid_q;
  out_word_t          out_q, out_d;
  logic               out_free;
  logic               accept;

  logic signed [18:0] sum_x, sum_y, sum_r;
  logic signed [18:0] off_x, off_y, off_r;

  // ---------------- configuration ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_trans_q <= '0;
      max_rot_q   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IDX_TRANS: max_trans_q <= cfg_data_i;
        CFG_IDX_ROT:   max_rot_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------- history chain, cell 0 newest ----------------
  assign tail     = cell_q[HISTORY_DEPTH-1];
  assign head_in  = (state_q == ST_WRITE) ? new_entry : tail;
  assign chain_en = (state_q == ST_SCAN) || (state_q == ST_WRITE && out_free &&
                                             cmd_q.action == ACT_ADD);

  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_head
      alh_cell u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .en_i  (chain_en),
        .d_i   (head_in),
        .q_o   (cell_q[g])
      );
    end else begin : g_body
      alh_cell u_cell (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .en_i  (chain_en),
        .d_i   (cell_q[g-1]),
        .q_o   (cell_q[g])
      );
    end
  end

  // ---------------- handshake ----------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rec_start  = (state_q == ST_START);

  // ---------------- difference stage ----------------
  assign dx     = 17'(cmd_q.vel_x) - 17'(old_q.vel_x);
  assign dy     = 17'(cmd_q.vel_y) - 17'(old_q.vel_y);
  assign dr     = 17'(cmd_q.rot_rate) - 17'(old_q.rot);
  assign abs_dx = dx[16] ? 17'(-dx) : 17'(dx);
  assign abs_dy = dy[16] ? 17'(-dy) : 17'(dy);
  assign abs_dr = dr[16] ? 17'(-dr) : 17'(dr);
  assign dt     = {1'b0, cmd_q.time_ms} - {1'b0, old_q.time_ms};

  // ---------------- step: floor, clamp, divide by 1000 ----------------
  always_comb begin
    if (!dtpos_q) begin
      st_d = STEP_FLOOR;
    end else if (satt_q) begin
      st_d = STEP_CLAMP;
    end else if (qmt_q[54:37] == '0) begin
      st_d = STEP_FLOOR;
    end else begin
      st_d = qmt_q[54:37];
    end
    if (!dtpos_q) begin
      sr_d = STEP_FLOOR;
    end else if (satr_q) begin
      sr_d = STEP_CLAMP;
    end else if (qmr_q[54:37] == '0) begin
      sr_d = STEP_FLOOR;
    end else begin
      sr_d = qmr_q[54:37];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_data_i;
      old_q <= cell_q[0];
    end
    if (state_q == ST_DIFF) begin
      dx_q     <= dx;
      dy_q     <= dy;
      dr_q     <= dr;
      adr_q    <= abs_dr[15:0];
      dtpos_q  <= !dt[32] && (dt[31:0] != '0);
      prod_t_q <= 48'(max_trans_q) * 48'(dt[31:0]);
      prod_r_q <= 48'(max_rot_q) * 48'(dt[31:0]);
      dx2_q    <= 32'(abs_dx[15:0]) * 32'(abs_dx[15:0]);
      dy2_q    <= 32'(abs_dy[15:0]) * 32'(abs_dy[15:0]);
    end
    if (state_q == ST_STEP_MUL) begin
      len2_q <= LEN_W'(dx2_q) + LEN_W'(dy2_q);
      satt_q <= prod_t_q >= STEP_SAT_LIM;
      satr_q <= prod_r_q >= STEP_SAT_LIM;
      qmt_q  <= 55'(prod_t_q[26:0]) * 55'(RECIP_1000);
      qmr_q  <= 55'(prod_r_q[26:0]) * 55'(RECIP_1000);
    end
    if (state_q == ST_STEP) begin
      st_q <= st_d;
      sr_q <= sr_d;
      m2_q <= 36'(st_d) * 36'(st_d);
    end
    if (state_q == ST_PP_LO) begin
      tlim_q <= {2'b0, len2_q} > m2_q;
      rlim_q <= {2'b0, adr_q} > sr_q;
      // m2 < len2 < 2^33 whenever the result is used
      plx_q  <= 49'(dx2_q) * 49'(m2_q[16:0]);
      ply_q  <= 49'(dy2_q) * 49'(m2_q[16:0]);
    end
    if (state_q == ST_PP_HI) begin
      r0x_q <= R_W'(plx_q) + (R_W'(48'(dx2_q) * 48'(m2_q[32:17])) << 17);
      r0y_q <= R_W'(ply_q) + (R_W'(48'(dy2_q) * 48'(m2_q[32:17])) << 17);
    end
  end

  alh_recur u_recur_x (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(rec_start),
    .r0_i  (r0x_q),
    .len2_i(len2_q),
    .busy_o(busy_x),
    .m_o   (mx)
  );

  alh_recur u_recur_y (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .start_i(rec_start),
    .r0_i  (r0y_q),
    .len2_i(len2_q),
    .busy_o(busy_y),
    .m_o   (my)
  );

  // ---------------- result assembly ----------------
  always_comb begin
    off_x = dx_q[16] ? -$signed({3'b0, mx}) : $signed({3'b0, mx});
    off_y = dy_q[16] ? -$signed({3'b0, my}) : $signed({3'b0, my});
    off_r = dr_q[16] ? -$signed({1'b0, sr_q}) : $signed({1'b0, sr_q});
    sum_x = 19'(old_q.vel_x) + off_x;
    sum_y = 19'(old_q.vel_y) + off_y;
    sum_r = 19'(old_q.rot) + off_r;

    new_entry.time_ms = cmd_q.time_ms;
    new_entry.vel_x   = tlim_q ? sat16(sum_x) : cmd_q.vel_x;
    new_entry.vel_y   = tlim_q ? sat16(sum_y) : cmd_q.vel_y;
    new_entry.rot     = rlim_q ? sat16(sum_r) : cmd_q.rot_rate;
    new_entry.kick    = cmd_q.kick_in;

    if (cmd_q.action == ACT_ADD) begin
      out_d.out_vel_x     = new_entry.vel_x;
      out_d.out_vel_y     = new_entry.vel_y;
      out_d.out_rot_rate  = new_entry.rot;
      out_d.out_kick      = new_entry.kick;
      out_d.trans_limited = tlim_q;
      out_d.rot_limited   = rlim_q;
    end else begin
      out_d.out_vel_x     = found_q.vel_x;
      out_d.out_vel_y     = found_q.vel_y;
      out_d.out_rot_rate  = found_q.rot;
      out_d.out_kick      = found_q.kick;
      out_d.trans_limited = 1'b0;
      out_d.rot_limited   = 1'b0;
    end
  end

  // ---------------- query scan, tail shows entries oldest first ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      run_q      <= 1'b0;
    end else if (accept) begin
      scan_cnt_q <= '0;
      run_q      <= 1'b1;
    end else if (state_q == ST_SCAN) begin
      scan_cnt_q <= scan_cnt_q + CNT_W'(1);
      if (scan_cnt_q != '0 && tail.time_ms > cmd_q.time_ms) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN) begin
      if (scan_cnt_q == '0) begin
        found_q <= tail;
      end else if (run_q && tail.time_ms <= cmd_q.time_ms) begin
        found_q <= tail;
      end
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_WRITE && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE && out_free) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.action == ACT_QUERY) ? ST_SCAN : ST_DIFF;
        end
      end
      ST_DIFF:     state_d = ST_STEP_MUL;
      ST_STEP_MUL: state_d = ST_STEP;
      ST_STEP:     state_d = ST_PP_LO;
      ST_PP_LO:    state_d = ST_PP_HI;
      ST_PP_HI:    state_d = ST_START;
      ST_START:    state_d = ST_REC;
      ST_REC: begin
        if (!busy_x && !busy_y) begin
          state_d = ST_WRITE;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_q == CNT_W'(HISTORY_DEPTH - 1)) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

`ifndef SYNTH
  a_rec_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REC) |-> (busy_x == busy_y))
    else $error("offset search units out of step");

  a_out_from_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_WRITE))
    else $error("result word raised outside write state");

  a_chain_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain_en |-> (state_q == ST_SCAN || state_q == ST_WRITE))
    else $error("history chain moved while busy elsewhere");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the drive history limiter: adds are slew-limited against the newest
// ring entry, queries look up entries by time. A local predictor builds each
// expected word, which is compared field by field as results leave the block.
// ----------------------------------------------------------------------------
module testbench;
  import alh_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 600000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_word_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_data_o;
  logic      cfg_we_i = 1'b0;
  logic      cfg_idx_i = CFG_IDX_TRANS;
  logic [15:0] cfg_data_i = '0;

  accel_limited_drive_history_top #(.HISTORY_DEPTH(DEPTH)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0]        ring_time [DEPTH];
  logic signed [15:0] ring_vx   [DEPTH];
  logic signed [15:0] ring_vy   [DEPTH];
  logic signed [15:0] ring_rot  [DEPTH];
  logic               ring_kick [DEPTH];
  int unsigned        next_slot;
  logic [15:0]        trans_accel, rot_accel;

  out_word_t pending_words [$];
  int        err_count = 0;
  int unsigned cycle_count = 0;
  bit        quiet = 1'b0;       // no idling on either side
  int        hold_req = 0, hold_seen = 0;

  function automatic longint unsigned allowed_step(logic [15:0] accel, longint dt);
    longint unsigned s;
    if (dt <= 0) return 1;
    s = (longint'(accel) * dt) / 1000;
    if (s < 1) s = 1;
    if (s > 131072) s = 131072;
    return s;
  endfunction

  // trunc(|d| * st / sqrt(len2)) with the sign of d, exact
  function automatic longint scaled_part(longint d, longint unsigned st,
                                         longint unsigned len2);
    longint unsigned ad, lo, hi, mid;
    logic [127:0] lhs, rhs;
    ad = (d < 0) ? -d : d;
    lo = 0;
    hi = st;
    rhs = 128'(ad * ad) * 128'(st * st);
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 128'(mid * mid) * 128'(len2);
      if (lhs <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return (d < 0) ? -longint'(lo) : longint'(lo);
  endfunction

  function automatic out_word_t limit_or_lookup(in_word_t w);
    out_word_t r;
    int unsigned nw, found, s;
    longint dt, dx, dy, dr;
    longint unsigned len2, st, sr, adr;
    r = '0;
    if (w.action == ACT_ADD) begin
      nw = (next_slot + DEPTH - 1) % DEPTH;
      dt = longint'(w.time_ms) - longint'(ring_time[nw]);
      dx = longint'(w.vel_x) - longint'(ring_vx[nw]);
      dy = longint'(w.vel_y) - longint'(ring_vy[nw]);
      dr = longint'(w.rot_rate) - longint'(ring_rot[nw]);
      len2 = dx * dx + dy * dy;
      st = allowed_step(trans_accel, dt);
      sr = allowed_step(rot_accel, dt);
      adr = (dr < 0) ? -dr : dr;
      r.out_vel_x = w.vel_x;
      r.out_vel_y = w.vel_y;
      r.out_rot_rate = w.rot_rate;
      if (len2 > st * st) begin
        r.trans_limited = 1'b1;
        r.out_vel_x = 16'(longint'(ring_vx[nw]) + scaled_part(dx, st, len2));
        r.out_vel_y = 16'(longint'(ring_vy[nw]) + scaled_part(dy, st, len2));
      end
      if (adr > sr) begin
        r.rot_limited = 1'b1;
        r.out_rot_rate = 16'(longint'(ring_rot[nw]) +
                             ((dr < 0) ? -longint'(sr) : longint'(sr)));
      end
      r.out_kick = w.kick_in;
      ring_time[next_slot] = w.time_ms;
      ring_vx[next_slot] = r.out_vel_x;
      ring_vy[next_slot] = r.out_vel_y;
      ring_rot[next_slot] = r.out_rot_rate;
      ring_kick[next_slot] = r.out_kick;
      next_slot = (next_slot + 1) % DEPTH;
    end else begin
      found = next_slot;
      for (int k = 1; k < DEPTH; k++) begin
        s = (next_slot + k) % DEPTH;
        if (ring_time[s] > w.time_ms) break;
        found = s;
      end
      r.out_vel_x = ring_vx[found];
      r.out_vel_y = ring_vy[found];
      r.out_rot_rate = ring_rot[found];
      r.out_kick = ring_kick[found];
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    if (quiet) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  function automatic in_word_t make_word(action_e a, logic [31:0] t, int x, int y,
                                         int r, bit k);
    in_word_t w;
    w.action = a;
    w.time_ms = t;
    w.vel_x = 16'(x);
    w.vel_y = 16'(y);
    w.rot_rate = 16'(r);
    w.kick_in = k;
    return w;
  endfunction

  task automatic send_word(in_word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (in_stall_o);
    pending_words.push_back(limit_or_lookup(w));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_IDX_TRANS) trans_accel = val;
    else rot_accel = val;
  endtask

  // receiver side: random stalls plus a long hold on request
  int unsigned stall_left = 0, hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      automatic int unsigned p = $urandom_range(0, 99);
      if (p < 60) out_stall_i <= 1'b0;
      else if (p < 93) begin
        stall_left <= $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else begin
        stall_left <= $urandom_range(10, 60);
        out_stall_i <= 1'b1;
      end
    end
  end

  // result check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t unexpected word: actual %p", $time, out_data_o);
        err_count++;
      end else begin
        automatic out_word_t e = pending_words.pop_front();
        if (e.out_vel_x !== out_data_o.out_vel_x) begin
          $display("%0t out_vel_x: expected %0d actual %0d", $time, e.out_vel_x,
                   out_data_o.out_vel_x);
          err_count++;
        end
        if (e.out_vel_y !== out_data_o.out_vel_y) begin
          $display("%0t out_vel_y: expected %0d actual %0d", $time, e.out_vel_y,
                   out_data_o.out_vel_y);
          err_count++;
        end
        if (e.out_rot_rate !== out_data_o.out_rot_rate) begin
          $display("%0t out_rot_rate: expected %0d actual %0d", $time,
                   e.out_rot_rate, out_data_o.out_rot_rate);
          err_count++;
        end
        if (e.out_kick !== out_data_o.out_kick) begin
          $display("%0t out_kick: expected %0b actual %0b", $time, e.out_kick,
                   out_data_o.out_kick);
          err_count++;
        end
        if (e.trans_limited !== out_data_o.trans_limited) begin
          $display("%0t trans_limited: expected %0b actual %0b", $time,
                   e.trans_limited, out_data_o.trans_limited);
          err_count++;
        end
        if (e.rot_limited !== out_data_o.rot_limited) begin
          $display("%0t rot_limited: expected %0b actual %0b", $time,
                   e.rot_limited, out_data_o.rot_limited);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // zero accel gives a step of one; extremes, time going backwards, lookups
  task automatic test_directed();
    send_word(make_word(ACT_QUERY, 32'd0, 0, 0, 0, 0));
    send_word(make_word(ACT_ADD, 32'd10, 32767, -32768, 32767, 1));
    send_word(make_word(ACT_ADD, 32'd20, 0, 0, 0, 0));
    drain();
    write_reg(CFG_IDX_TRANS, 16'd65535);
    write_reg(CFG_IDX_ROT, 16'd65535);
    send_word(make_word(ACT_ADD, 32'd1000, 32767, -32768, -32768, 1));
    send_word(make_word(ACT_ADD, 32'd2000, -32768, 32767, 32767, 0));
    send_word(make_word(ACT_ADD, 32'd2000, 0, 0, 0, 1));        // dt zero
    send_word(make_word(ACT_ADD, 32'd1500, 100, 100, 100, 0));  // time backwards
    send_word(make_word(ACT_ADD, 32'hFFFF_FFFF, -32768, -32768, -32768, 1));
    send_word(make_word(ACT_QUERY, 32'd0, 0, 0, 0, 0));
    send_word(make_word(ACT_QUERY, 32'd1500, 0, 0, 0, 0));
    send_word(make_word(ACT_QUERY, 32'd1999, 0, 0, 0, 0));
    send_word(make_word(ACT_QUERY, 32'hFFFF_FFFF, -1, -1, -1, 1));
    drain();
    write_reg(CFG_IDX_TRANS, 16'd1000);
    write_reg(CFG_IDX_ROT, 16'd500);
    send_word(make_word(ACT_ADD, 32'd5, 3000, 4000, 900, 0));
    send_word(make_word(ACT_ADD, 32'd7, -3, 7, -900, 1));
    send_word(make_word(ACT_ADD, 32'd8, 1, 1, 1, 0));
    send_word(make_word(ACT_QUERY, 32'd6, 0, 0, 0, 0));
    drain();
  endtask

  task automatic test_random(int n, logic [15:0] ta, logic [15:0] ra);
    logic [31:0] now;
    int cx, cy, cr;
    write_reg(CFG_IDX_TRANS, ta);
    write_reg(CFG_IDX_ROT, ra);
    now = $urandom;
    cx = 0;
    cy = 0;
    cr = 0;
    for (int i = 0; i < n; i++) begin
      automatic int unsigned p = $urandom_range(0, 99);
      if (p < 10) begin
        send_word(in_word_t'({$urandom, $urandom, $urandom}));
      end else if (p < 35) begin
        send_word(make_word(ACT_QUERY, now - $urandom_range(0, 400), $urandom,
                            $urandom, $urandom, 1'($urandom)));
      end else begin
        if ($urandom_range(0, 19) == 0) now = now - $urandom_range(1, 100);
        else now = now + $urandom_range(0, 60);
        if ($urandom_range(0, 4) == 0) begin
          cx = $signed(16'($urandom));
          cy = $signed(16'($urandom));
          cr = $signed(16'($urandom));
        end else begin
          cx = cx + $urandom_range(0, 400) - 200;
          cy = cy + $urandom_range(0, 400) - 200;
          cr = cr + $urandom_range(0, 400) - 200;
        end
        send_word(make_word(ACT_ADD, now, cx, cy, cr, 1'($urandom)));
      end
    end
    drain();
  endtask

  // receiver holds off while words keep coming in
  task automatic test_backpressure();
    hold_req <= hold_req + 1;
    for (int i = 0; i < 12; i++)
      send_word(make_word(action_e'($urandom_range(0, 1)), $urandom_range(0, 900),
                          $urandom, $urandom, $urandom, 1'($urandom)));
    drain();
  endtask

  task automatic test_no_idle();
    quiet = 1'b1;
    test_random(40, 16'd3000, 16'd2000);
    quiet = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      ring_time[i] = '0;
      ring_vx[i] = '0;
      ring_vy[i] = '0;
      ring_rot[i] = '0;
      ring_kick[i] = 1'b0;
    end
    next_slot = 0;
    trans_accel = '0;
    rot_accel = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(120, 16'd2000, 16'd1500);
    test_backpressure();
    test_random(120, 16'd0, 16'd65535);
    test_no_idle();
    test_random(120, 16'd65535, 16'd0);
    test_random(100, 16'($urandom), 16'($urandom));
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
